// ===== rtl/sorted_address_set_engine_defines.svh =====
// assertion macros for the sorted address set engine
`ifndef SORTED_ADDRESS_SET_ENGINE_DEFINES_SVH
`define SORTED_ADDRESS_SET_ENGINE_DEFINES_SVH

// checked only while out of reset
`define SASE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define SASE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/sase_pkg.sv =====
// shared types and constants of the sorted address set engine
package sase_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam int OP_W        = 2;
  localparam int ADDR_W      = 24;
  localparam int IN_TDATA_W  = 32;

  localparam int POS_W       = 12;
  localparam int CNT_OUT_W   = 13;
  localparam int REQ_W       = 32;
  localparam int FLUSH_W     = 16;
  localparam int OUT_USED_W  = 1 + POS_W + 1 + CNT_OUT_W + REQ_W + FLUSH_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic [FLUSH_W-1:0] ADDED_MAX = '1;

endpackage

// ===== rtl/sorted_address_set_engine.sv =====
// top level of the sorted address set engine
// Keeps up to CAPACITY unique addresses in ascending order in a single-port-write,
// single-port-read memory with registered read data, and serves one request at a
// time. A lookup runs a binary search with one shared comparator, each probe
// passing through the S_SRCH and S_PROBE states. An insert does the same search
// and then moves every entry above the insert point up by one place, one entry
// per cycle through the memory ports. Flush and clear go straight to S_DONE.
// in_tready is high only while no request is in progress; the result waits in
// an output register and the next request may be taken then.
`include "sorted_address_set_engine_defines.svh"

module sorted_address_set_engine
  import sase_pkg::*;
#(
  parameter int CAPACITY  = 4096,
  parameter int ADDR_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // op[1:0], address[25:2]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // found[0], position[12:1], accepted[13], entry_count[26:14],
  // request_number[58:27], flushed_count[74:59]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int KEY_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_PROBE = 6'b000100,
    S_CHECK = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] mem_rdata_r;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_wa;
  logic [IDX_W-1:0] mem_ra;
  logic [KEY_W-1:0] mem_wd;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [REQ_W-1:0]   req_id_r, req_id_nxt;
  logic               pending_r, pending_nxt;
  logic [FLUSH_W-1:0] added_r, added_nxt;
  logic               res_found_r, res_found_nxt;
  logic [POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic               res_acc_r, res_acc_nxt;
  logic [FLUSH_W-1:0] res_flush_r, res_flush_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  op_t              in_op;
  logic [ADDR_W-1:0] in_addr;
  logic             in_acc;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] j_dec;
  logic [31:0]      lo_ext;
  logic [31:0]      count_ext;
  logic             key_lt;
  logic             key_eq;

  assign in_op     = op_t'(in_tdata[OP_W-1:0]);
  assign in_addr   = in_tdata[OP_W +: ADDR_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign j_dec     = j_r - CNT_W'(1);
  assign lo_ext    = 32'(lo_r);
  assign count_ext = 32'(count_r);

  // shared compare unit
  assign key_lt = (mem_rdata_r < key_r);
  assign key_eq = (mem_rdata_r == key_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_ra];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    j_nxt          = j_r;
    wr_pend_nxt    = wr_pend_r;
    wr_addr_nxt    = wr_addr_r;
    count_nxt      = count_r;
    req_id_nxt     = req_id_r;
    pending_nxt    = pending_r;
    added_nxt      = added_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    res_acc_nxt    = res_acc_r;
    res_flush_nxt  = res_flush_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = wr_addr_r;
    mem_ra         = mid[IDX_W-1:0];
    mem_wd         = mem_rdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_op;
          key_nxt       = in_addr[KEY_W-1:0];
          lo_nxt        = '0;
          hi_nxt        = count_r;
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          res_acc_nxt   = 1'b0;
          res_flush_nxt = '0;
          unique case (in_op)
            OP_LOOKUP: begin
              state_nxt = S_SRCH;
            end
            OP_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            OP_FLUSH: begin
              if (pending_r) begin
                pending_nxt   = 1'b0;
                res_flush_nxt = added_r;
                added_nxt     = '0;
                req_id_nxt    = req_id_r + REQ_W'(1);
                res_acc_nxt   = 1'b1;
              end
              state_nxt = S_DONE;
            end
            OP_CLEAR: begin
              count_nxt  = '0;
              req_id_nxt = '0;
              state_nxt  = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r != hi_r) begin
          mem_re    = 1'b1;
          mem_ra    = mid[IDX_W-1:0];
          state_nxt = S_PROBE;
        end else if (lo_r != count_r) begin
          mem_re    = 1'b1;
          mem_ra    = lo_r[IDX_W-1:0];
          state_nxt = S_CHECK;
        end else if (op_r == OP_LOOKUP) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt       = count_r;
          wr_pend_nxt = 1'b0;
          state_nxt   = S_SHIFT;
        end
      end
      S_PROBE: begin
        if (key_lt) begin
          lo_nxt = mid + CNT_W'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH;
      end
      S_CHECK: begin
        if (op_r == OP_LOOKUP) begin
          res_found_nxt = key_eq;
          res_pos_nxt   = key_eq ? lo_ext[POS_W-1:0] : '0;
          state_nxt     = S_DONE;
        end else if (key_eq) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt       = count_r;
          wr_pend_nxt = 1'b0;
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (wr_pend_r) begin
          mem_we = 1'b1;
          mem_wa = wr_addr_r;
          mem_wd = mem_rdata_r;
        end
        if (j_r != lo_r) begin
          mem_re      = 1'b1;
          mem_ra      = j_dec[IDX_W-1:0];
          wr_addr_nxt = j_r[IDX_W-1:0];
          wr_pend_nxt = 1'b1;
          j_nxt       = j_dec;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            mem_we      = 1'b1;
            mem_wa      = lo_r[IDX_W-1:0];
            mem_wd      = key_r;
            count_nxt   = count_r + CNT_W'(1);
            pending_nxt = 1'b1;
            if (added_r != ADDED_MAX) begin
              added_nxt = added_r + FLUSH_W'(1);
            end
            res_acc_nxt = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, res_flush_r, req_id_r,
                            count_ext[CNT_OUT_W-1:0], res_acc_r, res_pos_r, res_found_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wr_pend_r    <= 1'b0;
      count_r      <= '0;
      req_id_r     <= '0;
      pending_r    <= 1'b0;
      added_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wr_pend_r    <= wr_pend_nxt;
      count_r      <= count_nxt;
      req_id_r     <= req_id_nxt;
      pending_r    <= pending_nxt;
      added_r      <= added_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    j_r         <= j_nxt;
    wr_addr_r   <= wr_addr_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_acc_r   <= res_acc_nxt;
    res_flush_r <= res_flush_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  `SASE_ASSERT(a_count_in_range, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `SASE_ASSERT(a_search_bounds, (state_r == S_SRCH) |-> (lo_r <= hi_r && hi_r <= count_r), "search window out of order")
  `SASE_ASSERT(a_shift_bounds, (state_r == S_SHIFT) |-> (j_r >= lo_r && j_r <= count_r), "shift pointer below insert point")
  `SASE_ASSERT(a_pending_clear, ($fell(pending_r) && $past(rst_n)) |-> $past(in_acc && in_op == OP_FLUSH), "pending mark dropped without flush")
  `SASE_ASSERT_RST(a_reset_state, !rst_n |=> (!pending_r && count_r == '0 && state_r == S_IDLE), "reset left state behind")

endmodule

// ===== test/address_set_checker.sv =====
// checker for the sorted address set engine: predicts each request's result and compares
module address_set_checker
  import sase_pkg::*;
#(
  parameter int CAPACITY = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     error_count,
  output int                     outstanding
);

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic               accepted;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [REQ_W-1:0]   request_number;
    logic [FLUSH_W-1:0] flushed_count;
  } set_result_t;

  logic [ADDR_W-1:0]  sorted_addrs [0:CAPACITY-1];
  int unsigned        set_size;
  logic [REQ_W-1:0]   cur_req_id;
  logic               pending;
  logic [FLUSH_W-1:0] added_count;
  set_result_t        expected_results [$];

  initial begin
    set_size    = 0;
    cur_req_id  = '0;
    pending     = 1'b0;
    added_count = '0;
    error_count = 0;
    outstanding = 0;
  end

  function automatic int unsigned first_not_below(logic [ADDR_W-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = set_size;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (sorted_addrs[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic apply_request(input op_t op, input logic [ADDR_W-1:0] key,
                               output set_result_t res);
    int unsigned slot;
    bit present;
    res = '0;
    case (op)
      OP_LOOKUP: begin
        slot = first_not_below(key);
        if (slot < set_size && sorted_addrs[slot] == key) begin
          res.found    = 1'b1;
          res.position = POS_W'(slot);
        end
      end
      OP_INSERT: begin
        slot = first_not_below(key);
        present = (slot < set_size) && (sorted_addrs[slot] == key);
        if (!present && set_size < CAPACITY) begin
          for (int unsigned j = set_size; j > slot; j--) sorted_addrs[j] = sorted_addrs[j-1];
          sorted_addrs[slot] = key;
          set_size++;
          pending = 1'b1;
          if (added_count != ADDED_MAX) added_count++;
          res.accepted = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (pending) begin
          pending = 1'b0;
          res.flushed_count = added_count;
          added_count = '0;
          cur_req_id++;
          res.accepted = 1'b1;
        end
      end
      default: begin
        set_size   = 0;
        cur_req_id = '0;
      end
    endcase
    res.entry_count    = CNT_OUT_W'(set_size);
    res.request_number = cur_req_id;
  endtask

  task automatic check_field(input string name, input logic [REQ_W-1:0] want,
                             input logic [REQ_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    set_result_t res;
    set_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("found", REQ_W'(want.found), REQ_W'(out_tdata[0]));
          check_field("position", REQ_W'(want.position), REQ_W'(out_tdata[12:1]));
          check_field("accepted", REQ_W'(want.accepted), REQ_W'(out_tdata[13]));
          check_field("entry_count", REQ_W'(want.entry_count), REQ_W'(out_tdata[26:14]));
          check_field("request_number", want.request_number, out_tdata[58:27]);
          check_field("flushed_count", REQ_W'(want.flushed_count), REQ_W'(out_tdata[74:59]));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_request(op_t'(in_tdata[1:0]), in_tdata[25:2], res);
        expected_results.push_back(res);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== test/tb_sorted_address_set_engine.sv =====
// testbench top for the sorted address set engine: stimulus, idling and verdict
module tb_sorted_address_set_engine;
  import sase_pkg::*;

  localparam int CAPACITY   = 4096;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 64;
  localparam int RAND_ITEMS = 122;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int error_count;
  int outstanding;
  int results_seen;
  int idle_cycles;

  sorted_address_set_engine #(.CAPACITY(CAPACITY), .ADDR_BITS(ADDR_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  address_set_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic send_request(input op_t op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, addr, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // result side: random stalls, plus a long hold-off now and then
  initial begin
    int gap;
    out_tready   = 1'b0;
    results_seen = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_seen % 2048 == 10) gap = LONG_HOLD;
        else gap = $urandom_range(0, 3);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] known_addrs [$];
    logic [ADDR_W-1:0] addr;
    op_t op;
    int pick;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty set, extremes, duplicates, flush with and without pending
    send_request(OP_LOOKUP, 24'h000000);
    send_request(OP_INSERT, 24'hFFFFFF);
    send_request(OP_INSERT, 24'h000000);
    send_request(OP_INSERT, 24'h800000);
    send_request(OP_INSERT, 24'h800000);
    send_request(OP_LOOKUP, 24'hFFFFFF);
    send_request(OP_LOOKUP, 24'h000000);
    send_request(OP_LOOKUP, 24'h800000);
    send_request(OP_LOOKUP, 24'h123456);
    send_request(OP_FLUSH, 24'h000000);
    send_request(OP_FLUSH, 24'hFFFFFF);
    send_request(OP_INSERT, 24'h7FFFFF);
    send_request(OP_CLEAR, 24'hFFFFFF);
    send_request(OP_LOOKUP, 24'hFFFFFF);
    send_request(OP_INSERT, 24'h55AA55);
    send_request(OP_CLEAR, 24'h000000);
    send_request(OP_FLUSH, 24'h000000);
    send_request(OP_FLUSH, 24'h000000);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) op = OP_INSERT;
      else if (pick < 77) op = OP_LOOKUP;
      else if (pick < 93) op = OP_FLUSH;
      else op = OP_CLEAR;
      if (known_addrs.size() > 0 && $urandom_range(0, 1))
        addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      else
        addr = ADDR_W'($urandom);
      if (op == OP_INSERT) known_addrs.push_back(addr);
      if (op == OP_CLEAR) known_addrs.delete();
      send_request(op, addr);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sase_pkg.sv
rtl/sorted_address_set_engine.sv
test/address_set_checker.sv
test/tb_sorted_address_set_engine.sv
